>>> rtl/avr_pkg.sv
// Package: item types, CORDIC constants and the arctangent table for the vector rotator.
`default_nettype none
package avr_pkg;

  localparam int VEC_W        = 32;
  localparam int AXIS_W       = 16;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int XY_W         = 33;
  localparam int Z_W          = 32;
  localparam int TRIG_W       = 32;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic signed [XY_W-1:0] ONE_Q30     = XY_W'(64'sd1 << 30);

  typedef struct packed {
    logic signed [VEC_W-1:0]   vec_x;
    logic signed [VEC_W-1:0]   vec_y;
    logic signed [VEC_W-1:0]   vec_z;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic        [ANGLE_W-1:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    in_item_t               item;
  } cordic_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    in_item_t                 item;
  } trig_t;

  // Arctangent of 2^-i as a fraction of a 32-bit turn.
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/avr_cordic_cell.sv
// One CORDIC rotation step as a registered cell of the sin/cos chain.
`default_nettype none
module avr_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             prev_valid,
  input  wire avr_pkg::cordic_t prev,
  output logic                  this_valid,
  output avr_pkg::cordic_t      this_stage
);
  import avr_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_turn(STEP);

  cordic_t stage_next;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  always_comb begin
    dx = prev.y >>> STEP;
    dy = prev.x >>> STEP;
    stage_next = prev;
    if (!prev.z[Z_W-1]) begin
      stage_next.x = prev.x - dx;
      stage_next.y = prev.y + dy;
      stage_next.z = prev.z - ATAN;
    end else begin
      stage_next.x = prev.x + dx;
      stage_next.y = prev.y - dy;
      stage_next.z = prev.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      this_valid <= 1'b0;
    end else if (adv) begin
      this_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      this_stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/avr_rotate.sv
// Rodrigues matrix build, matrix-vector product, rounding and saturation pipeline.
`default_nettype none
module avr_rotate (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             trig_valid,
  input  wire avr_pkg::trig_t   trig,
  output logic                  rsp_valid,
  output avr_pkg::out_item_t    rsp
);
  import avr_pkg::*;

  localparam int AA_W  = 2 * AXIS_W;
  localparam int AS_W  = AXIS_W + TRIG_W;
  localparam int OMC_W = TRIG_W + 2;
  localparam int T_W   = AA_W + OMC_W;
  localparam int M_W   = T_W + 1;
  localparam int Q_W   = 37;
  localparam int VH_W  = VEC_W - 16;
  localparam int PH_W  = Q_W + VH_W;
  localparam int PL_W  = Q_W + 17;
  localparam int SW    = Q_W + VEC_W + 3;
  localparam int RW    = SW - 27;
  localparam logic signed [RW-1:0] LIM_HI = {{(RW-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
  localparam logic signed [RW-1:0] LIM_LO = ~LIM_HI;

  // Stage A: axis products, axis times sine, one minus cosine.
  logic                      va;
  logic signed [AA_W-1:0]    aa [3][3];
  logic signed [AS_W-1:0]    as_a [3];
  logic signed [OMC_W-1:0]   omc_a;
  logic signed [TRIG_W-1:0]  c_a;
  in_item_t                  item_a;
  logic signed [AXIS_W-1:0]  ax [3];

  // Stage B: outer product scaled by one minus cosine.
  logic                      vb;
  logic signed [T_W-1:0]     t_b [3][3];
  logic signed [AS_W-1:0]    as_b [3];
  logic signed [TRIG_W-1:0]  c_b;
  in_item_t                  item_b;

  // Stage C: matrix entries in Q27.
  logic                      vc;
  logic signed [Q_W-1:0]     m_c [3][3];
  in_item_t                  item_c;
  logic signed [M_W-1:0]     m_full [3][3];

  // Stage D: partial products against high and low vector halves.
  logic                      vd;
  logic signed [PH_W-1:0]    ph [3][3];
  logic signed [PL_W-1:0]    pl [3][3];
  logic signed [VEC_W-1:0]   vv [3];

  // Stage E: rounded row sums.
  logic                      ve;
  logic signed [SW-1:0]      acc [3];

  logic signed [RW-1:0]      res [3];
  logic signed [VEC_W-1:0]   clip [3];
  logic        [2:0]         sat;

  assign ax[0] = trig.item.axis_x;
  assign ax[1] = trig.item.axis_y;
  assign ax[2] = trig.item.axis_z;
  assign vv[0] = item_c.vec_x;
  assign vv[1] = item_c.vec_y;
  assign vv[2] = item_c.vec_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m_full[r][k] = M_W'(t_b[r][k]) + M_W'(64'sd1 << 30);
      end
      m_full[r][r] = m_full[r][r] + (M_W'(c_b) <<< 28);
    end
    m_full[0][1] = m_full[0][1] - (M_W'(as_b[2]) <<< 14);
    m_full[1][0] = m_full[1][0] + (M_W'(as_b[2]) <<< 14);
    m_full[0][2] = m_full[0][2] + (M_W'(as_b[1]) <<< 14);
    m_full[2][0] = m_full[2][0] - (M_W'(as_b[1]) <<< 14);
    m_full[1][2] = m_full[1][2] - (M_W'(as_b[0]) <<< 14);
    m_full[2][1] = m_full[2][1] + (M_W'(as_b[0]) <<< 14);
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      res[r]  = RW'(acc[r] >>> 27);
      sat[r]  = (res[r] > LIM_HI) || (res[r] < LIM_LO);
      clip[r] = (res[r] > LIM_HI) ? LIM_HI[VEC_W-1:0] :
                (res[r] < LIM_LO) ? LIM_LO[VEC_W-1:0] : res[r][VEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      va <= trig_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      rsp_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          aa[r][k] <= ax[r] * ax[k];
          t_b[r][k] <= T_W'(aa[r][k]) * T_W'(omc_a);
          m_c[r][k] <= Q_W'(m_full[r][k] >>> 31);
          ph[r][k] <= PH_W'(m_c[r][k]) * PH_W'(vv[k] >>> 16);
          pl[r][k] <= PL_W'(m_c[r][k]) * $signed({{(PL_W-16){1'b0}}, vv[k][15:0]});
        end
        as_a[r] <= AS_W'(ax[r]) * AS_W'(trig.s);
        as_b[r] <= as_a[r];
        acc[r]  <= ((SW'(ph[r][0]) + SW'(ph[r][1]) + SW'(ph[r][2])) <<< 16)
                 + SW'(pl[r][0]) + SW'(pl[r][1]) + SW'(pl[r][2]) + SW'(64'sd1 << 26);
      end
      omc_a  <= OMC_W'(64'sd1 << 30) - OMC_W'(trig.c);
      c_a    <= trig.c;
      c_b    <= c_a;
      item_a <= trig.item;
      item_b <= item_a;
      item_c <= item_b;
      rsp.out_x     <= clip[0];
      rsp.out_y     <= clip[1];
      rsp.out_z     <= clip[2];
      rsp.saturated <= |sat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/axis_angle_vector_rotate.sv
// Top level of the axis-angle (Rodrigues) vector rotator.
`default_nettype none
// Rotates a Q16.16 vector about a Q2.14 axis (used as given, not normalized)
// by a 16-bit binary angle. Sine and cosine come from a chain of 24 CORDIC
// cells, one step per cell, followed by a clamp and quadrant stage; the
// matrix build and the matrix-vector product take six more stages, the last
// being the output register. One item enters per cycle while the output
// is not stalled. The whole pipeline advances together whenever the output
// register is empty or being drained, so a stalled result holds every stage
// and req_ready follows that same condition.
// Results round half up and clip to the 32-bit range, raising saturated.
module axis_angle_vector_rotate (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire avr_pkg::in_item_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output avr_pkg::out_item_t     rsp
);
  import avr_pkg::*;

  logic    adv;
  logic    vld [CORDIC_STEPS+1];
  cordic_t stg [CORDIC_STEPS+1];
  logic    trig_valid;
  trig_t   trig;
  trig_t   trig_next;
  logic signed [XY_W-1:0] cx;
  logic signed [XY_W-1:0] sy;
  cordic_t last;

  // Advance every stage when the output slot is free or being taken.
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  // Seed the chain: gain on x, low angle bits scaled to a 32-bit turn on z.
  always_comb begin
    stg[0].x    = CORDIC_GAIN;
    stg[0].y    = '0;
    stg[0].z    = {2'b00, req.turn_angle[13:0], 16'h0000};
    stg[0].zero = (req.turn_angle[13:0] == '0);
    stg[0].item = req;
    vld[0]      = req_valid;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    avr_cordic_cell #(.STEP(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .prev_valid (vld[i]),
      .prev       (stg[i]),
      .this_valid (vld[i+1]),
      .this_stage (stg[i+1])
    );
  end

  // Clamp to [-1, 1], force exact cos 1 / sin 0 on a zero residual, map quadrant.
  always_comb begin
    last = stg[CORDIC_STEPS];
    if (last.zero) begin
      cx = ONE_Q30;
      sy = '0;
    end else begin
      cx = (last.x > ONE_Q30) ? ONE_Q30 : (last.x < -ONE_Q30) ? -ONE_Q30 : last.x;
      sy = (last.y > ONE_Q30) ? ONE_Q30 : (last.y < -ONE_Q30) ? -ONE_Q30 : last.y;
    end
    trig_next.item = last.item;
    case (last.item.turn_angle[15:14])
      2'd0: begin
        trig_next.c = TRIG_W'(cx);
        trig_next.s = TRIG_W'(sy);
      end
      2'd1: begin
        trig_next.c = TRIG_W'(-sy);
        trig_next.s = TRIG_W'(cx);
      end
      2'd2: begin
        trig_next.c = TRIG_W'(-cx);
        trig_next.s = TRIG_W'(-sy);
      end
      default: begin
        trig_next.c = TRIG_W'(sy);
        trig_next.s = TRIG_W'(-cx);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_valid <= 1'b0;
    end else if (adv) begin
      trig_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig <= trig_next;
    end
  end

  avr_rotate u_rotate (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .trig_valid (trig_valid),
    .trig       (trig),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire

>>> rtl/avr_checker.sv
// Port-level checks for the vector rotator and their bind to the top level.
`default_nettype none
module avr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire avr_pkg::in_item_t  req,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire avr_pkg::out_item_t rsp
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // An empty output slot never blocks the input.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Input stalls only while a result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled without output back-pressure");

  // A waiting input item holds its value.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("waiting input item changed");

endmodule

bind axis_angle_vector_rotate avr_checker u_avr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire
